// ----- rtl/core/spnh_pkg.sv -----
// Package for the shortest-path next-hop unit: beat types, status codes,
// function codes and default sizes. Depends on nothing.
package spnh_pkg;

	localparam int NODES_DEF       = 8;
	localparam int WEIGHT_BITS_DEF = 8;
	localparam logic [15:0] COST_MAX = 16'hFFFF;

	typedef enum logic [0:0] {
		FUNC_WRITE = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_FOUND       = 2'd0,
		ST_OUT_OF_RANGE = 2'd1,
		ST_UNREACHABLE = 2'd2,
		ST_SELF        = 2'd3
	} route_status_t;

	typedef struct packed {
		func_t       func;
		logic [2:0]  from_node;
		logic [2:0]  to_node;
		logic [7:0]  edge_weight_in;
		logic [7:0]  dest_node;
	} cmd_t;

	typedef struct packed {
		route_status_t route_status;
		logic [2:0]    next_hop;
		logic [15:0]   route_cost;
	} rsp_t;

endpackage

// ----- rtl/core/spnh_link_table.sv -----
// Directed link-cost memory with one write and one registered read port.
// Clears itself after reset by a sweep; depends on spnh_pkg for defaults.
module spnh_link_table #(
	parameter int NODES       = spnh_pkg::NODES_DEF,
	parameter int WEIGHT_BITS = spnh_pkg::WEIGHT_BITS_DEF,
	localparam int DEPTH      = NODES * NODES,
	localparam int AW         = $clog2(DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  logic [WEIGHT_BITS-1:0] wr_data,
	input  logic [AW-1:0]          rd_addr,
	output logic [WEIGHT_BITS-1:0] rd_data,
	output logic                   busy
);

	logic [WEIGHT_BITS-1:0] mem [DEPTH];
	logic                   busy_q;
	logic [AW-1:0]          clr_q;
	logic                   we;
	logic [AW-1:0]          wa;
	logic [WEIGHT_BITS-1:0] wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we = busy_q | wr_en;
		wa = busy_q ? clr_q : wr_addr;
		wd = busy_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data <= mem[rd_addr];
	end

	assign busy = busy_q;

endmodule

// ----- rtl/core/shortest_path_next_hop_unit.sv -----
// Top level of the shortest-path next-hop unit: command decode, search FSM,
// per-node distance/predecessor memory. Depends on spnh_pkg, spnh_link_table.
//
//   channel | dir | handshake             | beat
//   cmd     | in  | cmd_valid / cmd_ready | spnh_pkg::cmd_t
//   rsp     | out | rsp_valid / rsp_ready | spnh_pkg::rsp_t
//   cfg     | in  | cfg_valid / cfg_ready | own_node, 3 bits
//
// An early-status query goes from the result register into the output
// register. A full search sets up in S_INIT, then runs up to NODES-1 rounds
// of S_SCAN, S_DRAIN and S_DECIDE, each scanning every link (one edge read
// from the link memory per cycle), then S_TRACE_RD and S_TRACE_CHK trace up
// to NODES-1 hops before the result goes into the output register. After
// reset the link memory is cleared by a sweep over its NODES*NODES entries,
// during which no command beat is taken. A result held by a stalled output
// lets command beats go on until the next result is ready; that result then
// waits, and no command beat is taken until the output frees.
module shortest_path_next_hop_unit #(
	parameter int NODES       = spnh_pkg::NODES_DEF,
	parameter int WEIGHT_BITS = spnh_pkg::WEIGHT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  spnh_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output spnh_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_data
);

	localparam int NB = $clog2(NODES);
	localparam int AW = $clog2(NODES * NODES);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_INIT      = 7'b0000010,
		S_SCAN      = 7'b0000100,
		S_DRAIN     = 7'b0001000,
		S_DECIDE    = 7'b0010000,
		S_TRACE_RD  = 7'b0100000,
		S_TRACE_CHK = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic                   emit_q;
	spnh_pkg::rsp_t         res_q;
	logic                   rsp_valid_q;
	spnh_pkg::rsp_t         rsp_q;
	logic [2:0]             own_node_q;
	logic [NB-1:0]          dest_q;
	logic [NB-1:0]          i_q;
	logic [NB-1:0]          j_q;
	logic                   v_s1;
	logic [NB-1:0]          i_s1;
	logic [NB-1:0]          j_s1;
	logic [NODES-1:0]       in_tree_q;
	logic                   found_q;
	logic [15:0]            best_q;
	logic [NB-1:0]          bi_q;
	logic [NB-1:0]          bj_q;
	logic [NB-1:0]          hop_q;
	logic [NB-1:0]          k_q;
	logic [15:0]            cost_q;

	logic [16+NB-1:0]       node_mem [NODES];
	logic [16+NB-1:0]       node_rd_q;
	logic                   node_we;
	logic [NB-1:0]          node_wa;
	logic [16+NB-1:0]       node_wd;
	logic [NB-1:0]          node_ra;

	logic                   link_we;
	logic [AW-1:0]          link_wa;
	logic [WEIGHT_BITS-1:0] link_wd;
	logic [AW-1:0]          link_ra;
	logic [WEIGHT_BITS-1:0] link_rd;
	logic                   link_busy;

	logic                   cmd_fire;
	logic                   out_free;
	logic [NB-1:0]          src;
	logic [WEIGHT_BITS+7:0] w_ext;
	logic [16:0]            sum;
	logic [15:0]            cand;
	logic                   take;
	logic [15:0]            rd_dist;
	logic [NB-1:0]          rd_pred;

	spnh_link_table #(
		.NODES       (NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (link_we),
		.wr_addr (link_wa),
		.wr_data (link_wd),
		.rd_addr (link_ra),
		.rd_data (link_rd),
		.busy    (link_busy)
	);

	assign cmd_ready = (state_q == S_IDLE) && !emit_q && !link_busy;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign src       = NB'(own_node_q);
	assign w_ext     = {{WEIGHT_BITS{1'b0}}, cmd.edge_weight_in};

	always_comb begin
		link_we = cmd_fire && (cmd.func == spnh_pkg::FUNC_WRITE)
			&& (32'(cmd.from_node) < NODES) && (32'(cmd.to_node) < NODES);
		link_wa = AW'(32'(cmd.from_node) * NODES + 32'(cmd.to_node));
		link_wd = w_ext[WEIGHT_BITS-1:0];
		link_ra = AW'(32'(i_q) * NODES + 32'(j_q));
	end

	always_comb begin
		rd_dist = node_rd_q[16+NB-1:NB];
		rd_pred = node_rd_q[NB-1:0];
		sum     = {1'b0, rd_dist} + 17'(link_rd);
		cand    = sum[16] ? spnh_pkg::COST_MAX : sum[15:0];
		take    = v_s1 && in_tree_q[i_s1] && (link_rd != '0) && !in_tree_q[j_s1]
			&& (!found_q || (cand < best_q));
	end

	always_comb begin
		node_we = 1'b0;
		node_wa = bj_q;
		node_wd = {best_q, bi_q};
		node_ra = (state_q == S_TRACE_RD) ? hop_q : i_q;
		if (state_q == S_INIT) begin
			node_we = 1'b1;
			node_wa = src;
			node_wd = '0;
		end else if (state_q == S_DECIDE && found_q) begin
			node_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_wa] <= node_wd;
		end
		node_rd_q <= node_mem[node_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_node_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			emit_q      <= 1'b0;
		end else begin
			if (emit_q && out_free) begin
				rsp_valid_q <= 1'b1;
				emit_q      <= 1'b0;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if ((state_q == S_IDLE && cmd_fire && cmd.func == spnh_pkg::FUNC_QUERY
					&& ((32'(cmd.dest_node) >= NODES) || (32'(own_node_q) >= NODES)
					|| (cmd.dest_node == 8'(own_node_q))))
				|| (state_q == S_DECIDE && !found_q)
				|| (state_q == S_TRACE_CHK && ((rd_pred == src)
					|| (k_q == NB'(NODES - 1))))) begin
				emit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_q && out_free) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			v_s1      <= 1'b0;
			found_q   <= 1'b0;
			in_tree_q <= '0;
		end else begin
			v_s1 <= (state_q == S_SCAN);
			if (take) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire && cmd.func == spnh_pkg::FUNC_QUERY) begin
						if (!((32'(cmd.dest_node) >= NODES) || (32'(own_node_q) >= NODES)
							|| (cmd.dest_node == 8'(own_node_q)))) begin
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					in_tree_q <= {{(NODES-1){1'b0}}, 1'b1} << src;
					found_q   <= 1'b0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					if (i_q == NB'(NODES - 1) && j_q == NB'(NODES - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					found_q <= 1'b0;
					if (!found_q) begin
						state_q <= S_IDLE;
					end else begin
						in_tree_q[bj_q] <= 1'b1;
						state_q <= (bj_q == dest_q) ? S_TRACE_RD : S_SCAN;
					end
				end
				S_TRACE_RD: begin
					state_q <= S_TRACE_CHK;
				end
				S_TRACE_CHK: begin
					if (rd_pred == src || k_q == NB'(NODES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TRACE_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= i_q;
		j_s1 <= j_q;
		if (take) begin
			best_q <= cand;
			bi_q   <= i_s1;
			bj_q   <= j_s1;
		end
		case (state_q)
			S_IDLE: begin
				dest_q <= NB'(cmd.dest_node);
				i_q    <= '0;
				j_q    <= '0;
				if (cmd_fire) begin
					if (32'(cmd.dest_node) >= NODES) begin
						res_q <= '{spnh_pkg::ST_OUT_OF_RANGE, 3'd0, 16'd0};
					end else if (32'(own_node_q) >= NODES) begin
						res_q <= '{spnh_pkg::ST_UNREACHABLE, 3'd0, 16'd0};
					end else begin
						res_q <= '{spnh_pkg::ST_SELF, 3'd0, 16'd0};
					end
				end
			end
			S_SCAN: begin
				if (j_q == NB'(NODES - 1)) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			S_DECIDE: begin
				i_q    <= '0;
				j_q    <= '0;
				hop_q  <= dest_q;
				k_q    <= '0;
				cost_q <= best_q;
				res_q  <= '{spnh_pkg::ST_UNREACHABLE, 3'd0, 16'd0};
			end
			S_TRACE_CHK: begin
				k_q   <= k_q + 1'b1;
				hop_q <= rd_pred;
				if (rd_pred == src) begin
					res_q <= '{spnh_pkg::ST_FOUND, 3'(hop_q), cost_q};
				end else begin
					res_q <= '{spnh_pkg::ST_FOUND, 3'(rd_pred), cost_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> (state_q == S_IDLE) && !link_busy)
		else $error("command taken outside idle");

	a_src_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DECIDE) |-> in_tree_q[src])
		else $error("own node missing from tree during search");

	a_new_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && found_q) |-> !in_tree_q[bj_q])
		else $error("chosen node already in tree");

	a_no_result_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DRAIN) |-> !emit_q)
		else $error("result pending while searching");

endmodule
